[sv/abpp_pkg.sv]
// ----------------------------------------------------------------------------
// abpp_pkg
// Shared types and constants for the alpha blending pixel plotter.
// ----------------------------------------------------------------------------
package abpp_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;

  localparam int PixW  = 32;
  localparam int CoordW = 16;
  localparam int SizeW  = 7;
  localparam int CfgIdxW = 8;

  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_HEIGHT = 8'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_FETCH,
    ST_MIX,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    CH_BLUE,
    CH_GREEN,
    CH_RED
  } channel_e;

endpackage

[sv/abpp_ram.sv]
// ----------------------------------------------------------------------------
// abpp_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module abpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/abpp_mix.sv]
// ----------------------------------------------------------------------------
// abpp_mix
// Channel mixer: (fg*a + bg*(255-a)) / 255, truncated, for one 8-bit channel.
// ----------------------------------------------------------------------------
module abpp_mix
  import abpp_pkg::*;
(
  input  logic [7:0] fg_i,
  input  logic [7:0] bg_i,
  input  logic [7:0] alpha_i,
  output logic [7:0] mix_o
);

  logic [15:0] fg_prod;
  logic [15:0] bg_prod;
  logic [15:0] sum;
  logic [16:0] quot;

  assign fg_prod = 16'(fg_i) * 16'(alpha_i);
  assign bg_prod = 16'(bg_i) * 16'(ALPHA_OPAQUE - alpha_i);
  assign sum     = fg_prod + bg_prod;
  // exact divide by 255 for sums of two 8x8 products
  assign quot    = 17'(sum) + 17'(sum[15:8]) + 17'd1;
  assign mix_o   = quot[15:8];

endmodule

[sv/alpha_blend_pixel_plotter.sv]
// ----------------------------------------------------------------------------
// alpha_blend_pixel_plotter
// ARGB8888 frame store with blended plot and pixel read commands.
// ----------------------------------------------------------------------------
// After reset the store is cleared one pixel a cycle, MAX_WIDTH * MAX_HEIGHT
// pixels (4096 by default), with s_axis_tready low; configuration writes are
// taken at all times. An item then occupies the block until it returns to
// idle: an out-of-range or fully transparent plot ends after locating, an
// opaque plot is written directly, a blended plot is fetched, mixed and written,
// and a read fetches and waits while the result register is full. The steps
// follow from the single frame store port and the one channel mixer, used once each for red, green and blue.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_plotter
  import abpp_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  // command items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // pos_x[15:0], pos_y[31:16], colour[63:32]
  input  logic               s_axis_tuser,  // cmd
  // read results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PixW-1:0]    m_axis_tdata   // read_data
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int AddrFullW = (AddrW > 15) ? AddrW : 15;
  localparam int CapW = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int CapH = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;

  state_e state_q, state_d;

  logic [SizeW-1:0]  aw_q, ah_q;
  logic              cmd_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [PixW-1:0]   colour_q;
  logic              in_area_q;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  clr_q;
  channel_e          ch_q;
  logic [23:0]       mix_q;
  logic              out_valid_q;
  logic [PixW-1:0]   out_data_q;

  logic [SizeW-1:0]     eff_w, eff_h;
  logic                 in_area;
  logic [AddrFullW-1:0] addr_full;
  logic [7:0]           alpha;
  logic [7:0]           fg_byte, bg_byte, mix_byte;
  logic [PixW-1:0]      rd_data;
  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_addr;
  logic [PixW-1:0]      ram_wdata;
  logic                 accept, out_load;

  assign cfg_ready_o = 1'b1;
  assign alpha       = colour_q[31:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= '0;
      ah_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_WIDTH:  aw_q <= cfg_data_i;
        CFG_ACTIVE_HEIGHT: ah_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (aw_q > SizeW'(CapW)) ? SizeW'(CapW) : aw_q;
  assign eff_h = (ah_q > SizeW'(CapH)) ? SizeW'(CapH) : ah_q;

  assign in_area = !x_q[15] && !y_q[15]
                && (x_q[14:0] < 15'(eff_w)) && (y_q[14:0] < 15'(eff_h));
  assign addr_full = AddrFullW'(y_q[6:0]) * AddrFullW'(eff_w) + AddrFullW'(x_q[6:0]);

  always_comb begin
    case (ch_q)
      CH_BLUE: begin
        fg_byte = colour_q[7:0];
        bg_byte = rd_data[7:0];
      end
      CH_GREEN: begin
        fg_byte = colour_q[15:8];
        bg_byte = rd_data[15:8];
      end
      CH_RED: begin
        fg_byte = colour_q[23:16];
        bg_byte = rd_data[23:16];
      end
      default: begin
        fg_byte = colour_q[7:0];
        bg_byte = rd_data[7:0];
      end
    endcase
  end

  abpp_mix u_mix (
    .fg_i    (fg_byte),
    .bg_i    (bg_byte),
    .alpha_i (alpha),
    .mix_o   (mix_byte)
  );

  abpp_ram #(
    .WIDTH (PixW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_data)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AddrW'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_LOCATE;
      end
      ST_LOCATE: begin
        if (cmd_q == CMD_READ) begin
          state_d = ST_FETCH;
        end else if (!in_area || alpha == ALPHA_CLEAR) begin
          state_d = ST_IDLE;
        end else if (alpha == ALPHA_OPAQUE) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = (cmd_q == CMD_READ) ? ST_RESP : ST_MIX;
      end
      ST_MIX: begin
        if (ch_q == CH_RED) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = addr_q;
    ram_wdata     = (alpha == ALPHA_OPAQUE) ? colour_q : {ALPHA_OPAQUE, mix_q};
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_FETCH: ram_re = 1'b1;
      ST_WRITE: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ch_q        <= CH_BLUE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (state_q == ST_MIX) begin
        ch_q <= (ch_q == CH_RED) ? CH_BLUE : channel_e'(ch_q + 2'd1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser;
      x_q      <= s_axis_tdata[15:0];
      y_q      <= s_axis_tdata[31:16];
      colour_q <= s_axis_tdata[63:32];
    end
    if (state_q == ST_LOCATE) begin
      in_area_q <= in_area;
      addr_q    <= addr_full[AddrW-1:0];
    end
    if (state_q == ST_MIX) begin
      case (ch_q)
        CH_BLUE:  mix_q[7:0]   <= mix_byte;
        CH_GREEN: mix_q[15:8]  <= mix_byte;
        CH_RED:   mix_q[23:16] <= mix_byte;
        default: ;
      endcase
    end
    if (out_load) out_data_q <= in_area_q ? rd_data : '0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[sim/tb_alpha_blend_pixel_plotter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_blend_pixel_plotter
// Checks plot and read commands against a behavioural copy of the frame store
// with blending, range checks and size saturation. Read data is compared with
// the predicted pixel in order, under random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_alpha_blend_pixel_plotter
  import abpp_pkg::*;
();

  localparam int StoreDepth   = DefMaxWidth * DefMaxHeight;
  localparam int SettleCycles = 16;
  localparam int StallLimit   = 20000;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 8'hFF;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [SizeW-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;  // pos_x[15:0], pos_y[31:16], colour[63:32]
  logic               s_axis_tuser;  // cmd
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [PixW-1:0]    m_axis_tdata;  // read_data

  logic [PixW-1:0]  pixel_mem [StoreDepth];
  logic [SizeW-1:0] width_reg;
  logic [SizeW-1:0] height_reg;
  logic [PixW-1:0]  pending_reads [$];
  logic [PixW-1:0]  want_pixel;
  int               errors;
  int               items_sent;
  int               reads_checked;
  int               cfg_writes;
  int               stall_count;
  bit               calm;

  alpha_blend_pixel_plotter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_size(logic [SizeW-1:0] v, int unsigned lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic bit locate_pixel(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                      output int unsigned addr);
    int unsigned w;
    int unsigned h;
    w = clamp_size(width_reg, DefMaxWidth);
    h = clamp_size(height_reg, DefMaxHeight);
    addr = 0;
    if (x[CoordW-1] || y[CoordW-1]) return 1'b0;
    if (x >= w || y >= h) return 1'b0;
    addr = y * w + x;
    return addr < StoreDepth;
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg,
                                             logic [7:0] alpha);
    int unsigned f;
    int unsigned b;
    int unsigned a;
    f = fg;
    b = bg;
    a = alpha;
    return 8'((f * a + b * (255 - a)) / 255);
  endfunction

  function automatic logic [PixW-1:0] blend_argb(logic [PixW-1:0] fg, logic [PixW-1:0] bg);
    return {ALPHA_OPAQUE,
            mix_channel(fg[23:16], bg[23:16], fg[31:24]),
            mix_channel(fg[15:8], bg[15:8], fg[31:24]),
            mix_channel(fg[7:0], bg[7:0], fg[31:24])};
  endfunction

  function automatic void apply_command(logic cmd, logic [CoordW-1:0] x,
                                        logic [CoordW-1:0] y, logic [PixW-1:0] colour);
    int unsigned addr;
    bit          hit;
    hit = locate_pixel(x, y, addr);
    if (cmd == CMD_READ) begin
      pending_reads.push_back(hit ? pixel_mem[addr] : '0);
    end else if (hit) begin
      if (colour[31:24] == ALPHA_OPAQUE) begin
        pixel_mem[addr] = colour;
      end else if (colour[31:24] != ALPHA_CLEAR) begin
        pixel_mem[addr] = blend_argb(colour, pixel_mem[addr]);
      end
    end
  endfunction

  function automatic logic [CoordW-1:0] random_coord(int unsigned lim);
    case ($urandom_range(0, 9))
      0: return CoordW'($urandom);
      1: return CoordW'(0 - $urandom_range(1, 4));
      default: return CoordW'($urandom_range(0, lim));
    endcase
  endfunction

  task automatic send_item(logic cmd, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           logic [PixW-1:0] colour);
    if (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {colour, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(cmd, x, y, colour);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ACTIVE_WIDTH) begin
      width_reg = val;
    end else if (idx == CFG_ACTIVE_HEIGHT) begin
      height_reg = val;
    end
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // plots give no result, so allow the last one to finish after the reads drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_size(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    drain();
    write_reg(CFG_ACTIVE_WIDTH, w);
    write_reg(CFG_ACTIVE_HEIGHT, h);
    write_reg(CfgNoReg, SizeW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_zero_size();
    send_item(CMD_PLOT, 16'd0, 16'd0, 32'hFF00FF00);
    send_item(CMD_READ, 16'd0, 16'd0, 32'h0);
    set_size(7'd8, 7'd0);
    send_item(CMD_PLOT, 16'd1, 16'd0, 32'hFF0000FF);
    send_item(CMD_READ, 16'd1, 16'd0, 32'h0);
  endtask

  task automatic test_corners();
    set_size(7'd64, 7'd64);
    send_item(CMD_PLOT, 16'd0, 16'd0, 32'hFFFFFFFF);
    send_item(CMD_PLOT, 16'd63, 16'd63, 32'hFF123456);
    send_item(CMD_READ, 16'd0, 16'd0, 32'h0);
    send_item(CMD_READ, 16'd63, 16'd63, 32'hFFFFFFFF);
    send_item(CMD_PLOT, 16'd0, 16'd0, 32'h00ABCDEF);
    send_item(CMD_READ, 16'd0, 16'd0, 32'h0);
  endtask

  task automatic test_blending();
    send_item(CMD_PLOT, 16'd63, 16'd63, 32'h01000000);
    send_item(CMD_READ, 16'd63, 16'd63, 32'h0);
    send_item(CMD_PLOT, 16'd63, 16'd63, 32'h80FF00FF);
    send_item(CMD_READ, 16'd63, 16'd63, 32'h0);
    send_item(CMD_PLOT, 16'd0, 16'd0, 32'hFE808080);
    send_item(CMD_READ, 16'd0, 16'd0, 32'h0);
  endtask

  task automatic test_out_of_range();
    send_item(CMD_PLOT, 16'd64, 16'd0, 32'hFFAAAAAA);
    send_item(CMD_PLOT, 16'hFFFF, 16'd5, 32'hFFAAAAAA);
    send_item(CMD_PLOT, 16'd5, 16'h8000, 32'hFFAAAAAA);
    send_item(CMD_PLOT, 16'h7FFF, 16'h7FFF, 32'hFFAAAAAA);
    send_item(CMD_READ, 16'h8000, 16'd0, 32'hFFFFFFFF);
    send_item(CMD_READ, 16'd0, 16'd64, 32'hFFFFFFFF);
    send_item(CMD_READ, 16'd0, 16'd1, 32'h0);
  endtask

  task automatic test_saturated_size();
    set_size(7'd127, 7'd127);
    send_item(CMD_PLOT, 16'd64, 16'd5, 32'hFF00FF00);
    send_item(CMD_READ, 16'd63, 16'd63, 32'h0);
  endtask

  task automatic test_random_phase(logic [SizeW-1:0] w, logic [SizeW-1:0] h, int count,
                                   bit quiet, bit hold_midway);
    int unsigned     ew;
    int unsigned     eh;
    logic            cmd;
    logic [7:0]      alpha;
    logic [PixW-1:0] colour;
    set_size(w, h);
    calm = quiet;
    ew = clamp_size(w, DefMaxWidth);
    eh = clamp_size(h, DefMaxHeight);
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < 40) ? CMD_READ : CMD_PLOT;
      case ($urandom_range(0, 9))
        0, 1: alpha = ALPHA_CLEAR;
        2, 3: alpha = ALPHA_OPAQUE;
        default: alpha = 8'($urandom);
      endcase
      colour = {alpha, 24'($urandom)};
      send_item(cmd, random_coord(ew), random_coord(eh), colour);
      if (hold_midway && i == count / 2) drain();
    end
    calm = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: read result with none pending: expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want_pixel = pending_reads.pop_front();
        reads_checked++;
        if (m_axis_tdata !== want_pixel) begin
          errors++;
          $display("%0t: read_data mismatch: expected %h, actual %h",
                   $time, want_pixel, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PLOT;
    calm          = 1'b0;
    errors        = 0;
    items_sent    = 0;
    reads_checked = 0;
    cfg_writes    = 0;
    stall_count   = 0;
    width_reg     = '0;
    height_reg    = '0;
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_size();
    test_corners();
    test_blending();
    test_out_of_range();
    test_saturated_size();
    test_random_phase(7'd64, 7'd64, 260, 1'b0, 1'b1);
    test_random_phase(7'd5, 7'd3, 200, 1'b0, 1'b0);
    test_random_phase(7'd1, 7'd1, 120, 1'b0, 1'b0);
    test_random_phase(7'd127, 7'd2, 180, 1'b1, 1'b0);
    test_random_phase(7'd3, 7'd127, 180, 1'b0, 1'b0);
    test_random_phase(7'd0, 7'd9, 60, 1'b0, 1'b0);
    test_random_phase(7'd17, 7'd13, 220, 1'b0, 1'b0);
    test_random_phase(7'd64, 7'd64, 200, 1'b0, 1'b0);

    drain();
    $display("Covered %0d command items and %0d register writes, sizes 0 to 127;",
             items_sent, cfg_writes);
    $display("%0d read results checked, %0d errors.", reads_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/abpp_pkg.sv
sv/abpp_ram.sv
sv/abpp_mix.sv
sv/alpha_blend_pixel_plotter.sv
sim/tb_alpha_blend_pixel_plotter.sv
